[src/ursc_pkg.sv]
// Shared types and constants for the ultrasonic ranger controller.
// No dependencies; used by ursc_seq, ursc_dist and the top level.
`default_nettype none

package ursc_pkg;

	// counter width of the tick counters
	localparam int CNT_BITS = 26;
	// widths of the configuration registers
	localparam int PERIOD_W = 26;
	localparam int PULSE_W  = 16;
	localparam int TMO_W    = 26;
	localparam int LIMIT_W  = 4;
	localparam int CFG_W    = 26;
	localparam int CFG_IDX_W = 2;
	localparam int CMP_W    = (CNT_BITS > PERIOD_W) ? CNT_BITS : PERIOD_W;

	localparam int DIST_W = 20;
	localparam logic [DIST_W-1:0] DIST_MAX = 20'h7FFFF;
	localparam logic [DIST_W-1:0] DIST_NEG_ONE = '1;

	// distance = floor(floor(w*10/27)/58) = floor(5w/783)
	// 5w has CNT_BITS+3 bits; reciprocal with 10 guard bits is exact over that range
	localparam int DIST_DIV  = 27 * 58 / 2;
	localparam int RCP_SHIFT = CNT_BITS + 3 + 10;
	localparam longint unsigned RCP =
		((64'd1 << RCP_SHIFT) + longint'(DIST_DIV) - 64'd1) / longint'(DIST_DIV);
	localparam int MUL_W  = CNT_BITS + 6;
	localparam logic [MUL_W-1:0] RCP5 = MUL_W'(RCP * 64'd5);
	localparam int PROD_W = CNT_BITS + MUL_W;
	localparam int QUO_W  = PROD_W - RCP_SHIFT;

	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 2'd3;

	localparam logic [PERIOD_W-1:0] RST_TRIGGER_PERIOD = 26'd2700000;
	localparam logic [PULSE_W-1:0]  RST_TRIGGER_WIDTH  = 16'd270;
	localparam logic [TMO_W-1:0]    RST_ECHO_TIMEOUT   = 26'd810000;
	localparam logic [LIMIT_W-1:0]  RST_ERROR_LIMIT    = 4'd3;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_TRIG = 3'd1,
		PH_RISE = 3'd2,
		PH_FALL = 3'd3,
		PH_ERR  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] trigger_period;
		logic [PULSE_W-1:0]  trigger_width;
		logic [TMO_W-1:0]    echo_timeout;
		logic [LIMIT_W-1:0]  error_limit;
	} cfg_t;

	// per-tick flags leaving the sequencer
	typedef struct packed {
		logic   trig;
		phase_t phase;
		logic   done;
		logic   tmo;
		logic   force_neg;
	} flags_t;

	typedef struct packed {
		flags_t              f;
		logic [CNT_BITS-1:0] width;
	} tick_t;

	typedef struct packed {
		logic              timeout_seen;
		logic              measure_done;
		logic [2:0]        phase;
		logic [DIST_W-1:0] distance;
		logic              trigger_level;
	} result_t;

endpackage

`default_nettype wire

[src/ursc_seq.sv]
// Phase sequencer: counters, phase register and stage 1 result register.
// Depends on ursc_pkg.
`default_nettype none

module ursc_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            accept,
	input  wire logic            echo,
	input  wire ursc_pkg::cfg_t  cfg,
	output logic                 v_s1,
	output ursc_pkg::tick_t      res_s1
);

	localparam int CNT_BITS = ursc_pkg::CNT_BITS;
	localparam int CMP_W    = ursc_pkg::CMP_W;

	ursc_pkg::phase_t phase_q, phase_d;
	logic [CNT_BITS-1:0] since_q, since_d, width_q, width_d;
	logic [ursc_pkg::PULSE_W-1:0] pulse_q, pulse_d, pulse_inc;
	logic [ursc_pkg::LIMIT_W-1:0] err_q, err_d;
	logic since_sat, width_sat, period_hit, rise_exp, fall_exp;
	logic [CNT_BITS-1:0] since_up, width_up;
	ursc_pkg::flags_t flags;

	assign since_sat = (since_q == '1);
	assign width_sat = (width_q == '1);
	assign since_up  = since_sat ? since_q : since_q + 1'b1;
	assign width_up  = width_sat ? width_q : width_q + 1'b1;
	assign pulse_inc = (pulse_q == '1) ? pulse_q : pulse_q + 1'b1;

	// a saturated counter always counts as expired
	assign period_hit = (CMP_W'(since_q) >= CMP_W'(cfg.trigger_period)) || since_sat;
	assign rise_exp   = (CMP_W'(since_q) > CMP_W'(cfg.echo_timeout)) || since_sat;
	assign fall_exp   = (CMP_W'(width_q) > CMP_W'(cfg.echo_timeout)) || width_sat;

	// next state
	always_comb begin
		phase_d = phase_q;
		since_d = since_q;
		width_d = width_q;
		pulse_d = pulse_q;
		err_d   = err_q;
		case (phase_q)
			ursc_pkg::PH_IDLE: begin
				if (period_hit) begin
					phase_d = ursc_pkg::PH_TRIG;
					pulse_d = '0;
				end
				since_d = since_up;
			end
			ursc_pkg::PH_TRIG: begin
				pulse_d = pulse_inc;
				if (pulse_inc >= cfg.trigger_width) begin
					phase_d = ursc_pkg::PH_RISE;
					since_d = '0;
					pulse_d = '0;
				end
			end
			ursc_pkg::PH_RISE: begin
				if (echo) begin
					phase_d = ursc_pkg::PH_FALL;
					width_d = '0;
				end else if (rise_exp) begin
					phase_d = ursc_pkg::PH_ERR;
				end
				since_d = since_up;
			end
			ursc_pkg::PH_FALL: begin
				if (!echo) begin
					phase_d = ursc_pkg::PH_IDLE;
					err_d   = '0;
				end else if (fall_exp) begin
					phase_d = ursc_pkg::PH_ERR;
				end
				width_d = width_up;
				since_d = since_up;
			end
			ursc_pkg::PH_ERR: begin
				err_d   = (err_q == '1) ? err_q : err_q + 1'b1;
				phase_d = ursc_pkg::PH_IDLE;
				since_d = '0;
			end
			default: begin
				phase_d = ursc_pkg::PH_IDLE;
			end
		endcase
	end

	// per-tick outputs
	always_comb begin
		flags.trig      = (phase_q == ursc_pkg::PH_TRIG);
		flags.phase     = phase_d;
		flags.done      = (phase_q == ursc_pkg::PH_FALL) && !echo;
		flags.tmo       = ((phase_q == ursc_pkg::PH_RISE) && !echo && rise_exp)
			|| ((phase_q == ursc_pkg::PH_FALL) && echo && fall_exp);
		flags.force_neg = (phase_q == ursc_pkg::PH_ERR) && (err_d > cfg.error_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ursc_pkg::PH_IDLE;
			since_q <= '0;
			width_q <= '0;
			pulse_q <= '0;
			err_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			since_q <= since_d;
			width_q <= width_d;
			pulse_q <= pulse_d;
			err_q   <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	// echo width as it stood at the start of the tick feeds the conversion
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.f     <= flags;
			res_s1.width <= width_q;
		end
	end

endmodule

`default_nettype wire

[src/ursc_dist.sv]
// Width-to-distance conversion (reciprocal multiply) and output register.
// Depends on ursc_pkg.
`default_nettype none

module ursc_dist (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             v_s1,
	input  wire ursc_pkg::tick_t  res_s1,
	output logic                  out_valid,
	output ursc_pkg::result_t     result
);

	localparam int QUO_W  = ursc_pkg::QUO_W;
	localparam int DIST_W = ursc_pkg::DIST_W;

	logic v_s2;
	ursc_pkg::flags_t f_s2;
	logic [ursc_pkg::PROD_W-1:0] prod_s2;
	logic [QUO_W-1:0] quo;
	logic [DIST_W-1:0] dist_new, dist_q, dist_d;

	assign quo = prod_s2[ursc_pkg::PROD_W-1:ursc_pkg::RCP_SHIFT];
	// saturation only bites for wider counters
	assign dist_new = (quo > QUO_W'(ursc_pkg::DIST_MAX)) ? ursc_pkg::DIST_MAX
		: DIST_W'(quo);

	always_comb begin
		dist_d = dist_q;
		if (f_s2.done) begin
			dist_d = dist_new;
		end else if (f_s2.force_neg) begin
			dist_d = ursc_pkg::DIST_NEG_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
			dist_q    <= '0;
		end else if (en) begin
			v_s2      <= v_s1;
			out_valid <= v_s2;
			if (v_s2) begin
				dist_q <= dist_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			f_s2    <= res_s1.f;
			prod_s2 <= ursc_pkg::PROD_W'(res_s1.width) * ursc_pkg::PROD_W'(ursc_pkg::RCP5);
		end
		if (en && v_s2) begin
			result.trigger_level <= f_s2.trig;
			result.distance      <= dist_d;
			result.phase         <= f_s2.phase;
			result.measure_done  <= f_s2.done;
			result.timeout_seen  <= f_s2.tmo;
		end
	end

endmodule

`default_nettype wire

[src/ultrasonic_ranger_controller.sv]
// Ultrasonic echo ranging controller, top level.
// Depends on ursc_pkg, ursc_seq and ursc_dist.
//
//  port group   dir  word                          meaning
//  s_axis_*     in   [0] echo_level                one timer tick, sampled echo
//  m_axis_*     out  trigger/distance/phase/flags  one result word per tick
//  cfg_*        in   index + data, write only      trigger_period, trigger_width,
//                                                  echo_timeout, error_limit
//
// One tick word accepted per cycle while the output is not stalled; its result
// passes the sequencer register, multiply register and output register.
// The phase counters update in the cycle of acceptance, so ticks follow
// back to back; the distance conversion is a single 26x32 multiply.
// Reset clears phase, counters, error run and distance; registers take
// their default values. A stalled output freezes the whole pipeline and
// drops s_axis_tready in the same cycle.
`default_nettype none

module ultrasonic_ranger_controller (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [0] echo_level, [7:1] zero
	input  wire logic [7:0]                        s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [0] trigger_level, [20:1] distance, [23:21] phase, [24] measure_done,
	// [25] timeout_seen, [31:26] zero
	output logic [31:0]                            m_axis_tdata,
	input  wire logic                              cfg_we,
	input  wire logic [ursc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ursc_pkg::CFG_W-1:0]        cfg_data
);

	ursc_pkg::cfg_t cfg_q;
	ursc_pkg::tick_t res_s1;
	ursc_pkg::result_t result;
	logic en, accept, v_s1, out_valid;

	// pipeline advances whenever the output register is free or being drained
	assign en            = !out_valid || m_axis_tready;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_period <= ursc_pkg::RST_TRIGGER_PERIOD;
			cfg_q.trigger_width  <= ursc_pkg::RST_TRIGGER_WIDTH;
			cfg_q.echo_timeout   <= ursc_pkg::RST_ECHO_TIMEOUT;
			cfg_q.error_limit    <= ursc_pkg::RST_ERROR_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				ursc_pkg::REG_TRIGGER_PERIOD: begin
					cfg_q.trigger_period <= cfg_data[ursc_pkg::PERIOD_W-1:0];
				end
				ursc_pkg::REG_TRIGGER_WIDTH: begin
					cfg_q.trigger_width <= cfg_data[ursc_pkg::PULSE_W-1:0];
				end
				ursc_pkg::REG_ECHO_TIMEOUT: begin
					cfg_q.echo_timeout <= cfg_data[ursc_pkg::TMO_W-1:0];
				end
				ursc_pkg::REG_ERROR_LIMIT: begin
					cfg_q.error_limit <= cfg_data[ursc_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ursc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.accept (accept),
		.echo   (s_axis_tdata[0]),
		.cfg    (cfg_q),
		.v_s1   (v_s1),
		.res_s1 (res_s1)
	);

	ursc_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.v_s1      (v_s1),
		.res_s1    (res_s1),
		.out_valid (out_valid),
		.result    (result)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata  = {6'd0, result};

	// a tick cannot both finish a measurement and time out
	a_done_tmo_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(result.measure_done && result.timeout_seen))
		else $error("measure_done and timeout_seen together");

	// a finished measurement always returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result.measure_done) |-> (result.phase == ursc_pkg::PH_IDLE))
		else $error("measure_done outside idle");

	// a timeout always lands in the error phase
	a_tmo_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result.timeout_seen) |-> (result.phase == ursc_pkg::PH_ERR))
		else $error("timeout_seen without error phase");

	// trigger only leaves towards awaiting the echo rise
	a_trig_next: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result.trigger_level) |->
		(result.phase == ursc_pkg::PH_TRIG || result.phase == ursc_pkg::PH_RISE))
		else $error("bad phase after trigger tick");

	// a stalled output holds back the input side in the same cycle
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while output stalled");

endmodule

`default_nettype wire
